// ===== design/two_pole_two_zero_voltage_compensator_macros.svh =====
// Assertion macros shared by the compensator RTL.
`ifndef TWO_POLE_TWO_ZERO_VOLTAGE_COMPENSATOR_MACROS_SVH
`define TWO_POLE_TWO_ZERO_VOLTAGE_COMPENSATOR_MACROS_SVH
// Property must hold at every clock edge out of reset.
`define TPTZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen out of reset.
`define TPTZ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

// ===== design/tptz_pkg.sv =====
// Types, constants and microprogram of the 2P2Z voltage compensator.
`timescale 1ns / 1ps
`default_nettype none
package tptz_pkg;

  localparam int ADC_BITS_DEF    = 12;
  localparam int PERIOD_BITS_DEF = 16;

  localparam int COEF_W     = 16;
  localparam int REF_W      = 16;
  localparam int DUTY_W     = 24;
  localparam int ERR_W      = 17;
  localparam int SEED_W     = 15;
  localparam int DC_W       = 15;
  localparam int ACC_W      = 48;
  localparam int ROUND_SHIFT = 18;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 3;

  localparam int unsigned VSCALE    = 40560;
  localparam int unsigned FULL_DUTY = 25600;

  localparam logic [REF_W-1:0]  VREF_RST = 16'd20480;
  localparam logic [COEF_W-1:0] A1_RST   = 16'd10376;
  localparam logic [COEF_W-1:0] A2_RST   = 16'd6008;
  localparam logic [COEF_W-1:0] B0_RST   = 16'd3351;
  localparam logic [COEF_W-1:0] B1_RST   = 16'hEC48;  // -5048
  localparam logic [COEF_W-1:0] B2_RST   = 16'd2523;
  localparam int unsigned       PERIOD_RST = 6400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VREF   = 3'd0,
    REG_A1     = 3'd1,
    REG_A2     = 3'd2,
    REG_B0     = 3'd3,
    REG_B1     = 3'd4,
    REG_B2     = 3'd5,
    REG_PERIOD = 3'd6,
    REG_SEED   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_SCALE = 3'd1,
    MUL_A1D1  = 3'd2,
    MUL_A2D2  = 3'd3,
    MUL_B0E0  = 3'd4,
    MUL_B1E1  = 3'd5,
    MUL_B2E2  = 3'd6,
    MUL_PDC   = 3'd7
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD16 = 2'd1,
    ACC_ADD16  = 2'd2,
    ACC_ADD    = 2'd3
  } acc_op_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ERR     = 3'd1,
    OP_DUTY    = 3'd2,
    OP_RECIP   = 3'd3,
    OP_EMIT    = 3'd4
  } dp_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT    = 2'd0,
    JMP_WAIT_IN = 2'd1,
    JMP_EMIT    = 2'd2
  } jmp_t;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ST_IDLE    = 4'd0;
  localparam pc_t ST_SCALE   = 4'd1;
  localparam pc_t ST_ERR     = 4'd2;
  localparam pc_t ST_A2      = 4'd3;
  localparam pc_t ST_B0      = 4'd4;
  localparam pc_t ST_B1      = 4'd5;
  localparam pc_t ST_B2      = 4'd6;
  localparam pc_t ST_SUM     = 4'd7;
  localparam pc_t ST_DUTY    = 4'd8;
  localparam pc_t ST_CMP     = 4'd9;
  localparam pc_t ST_RECIP   = 4'd10;
  localparam pc_t ST_EMIT    = 4'd11;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    dp_op_t   op;
    jmp_t     jmp;
    pc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic out_stall;
  } stat_t;

  typedef struct packed {
    logic [REF_W-1:0]  vref;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
  } cfg_t;

  function automatic ctrl_t cw(input mul_sel_t m, input acc_op_t a, input dp_op_t o,
                               input jmp_t j, input pc_t t);
    ctrl_t w;
    w.mul    = m;
    w.acc    = a;
    w.op     = o;
    w.jmp    = j;
    w.target = t;
    return w;
  endfunction

  // Each multiply lands in the product register; the accumulate or operation
  // field of the next word consumes it.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    case (pc)
      ST_IDLE:    w = cw(MUL_NONE,  ACC_HOLD,   OP_NONE,    JMP_WAIT_IN, ST_IDLE);
      ST_SCALE:   w = cw(MUL_SCALE, ACC_HOLD,   OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_ERR:     w = cw(MUL_A1D1,  ACC_HOLD,   OP_ERR,     JMP_NEXT,    ST_IDLE);
      ST_A2:      w = cw(MUL_A2D2,  ACC_LOAD16, OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_B0:      w = cw(MUL_B0E0,  ACC_ADD16,  OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_B1:      w = cw(MUL_B1E1,  ACC_ADD,    OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_B2:      w = cw(MUL_B2E2,  ACC_ADD,    OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_SUM:     w = cw(MUL_NONE,  ACC_ADD,    OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_DUTY:    w = cw(MUL_NONE,  ACC_HOLD,   OP_DUTY,    JMP_NEXT,    ST_IDLE);
      ST_CMP:     w = cw(MUL_PDC,   ACC_HOLD,   OP_NONE,    JMP_NEXT,    ST_IDLE);
      ST_RECIP:   w = cw(MUL_NONE,  ACC_HOLD,   OP_RECIP,   JMP_NEXT,    ST_IDLE);
      ST_EMIT:    w = cw(MUL_NONE,  ACC_HOLD,   OP_EMIT,    JMP_EMIT,    ST_IDLE);
      default:    w = cw(MUL_NONE,  ACC_HOLD,   OP_NONE,    JMP_EMIT,    ST_IDLE);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== design/tptz_seq.sv =====
// Microprogram sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps
`default_nettype none
`include "two_pole_two_zero_voltage_compensator_macros.svh"
module tptz_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tptz_pkg::stat_t stat,
  output tptz_pkg::ctrl_t ctrl,
  output logic            in_ready
);
  import tptz_pkg::*;

  pc_t pc_r;
  pc_t pc_nxt;

  assign ctrl     = ucode(pc_r);
  assign in_ready = (pc_r == ST_IDLE);

  always_comb begin
    case (ctrl.jmp)
      JMP_NEXT:    pc_nxt = pc_r + 1'b1;
      JMP_WAIT_IN: pc_nxt = in_valid ? pc_r + 1'b1 : pc_r;
      JMP_EMIT:    pc_nxt = stat.out_stall ? pc_r : ctrl.target;
      default:     pc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `TPTZ_NEVER(a_pc_range, pc_r > ST_EMIT, "step counter left the program")
  `TPTZ_ASSERT(a_recip_next, (pc_r == ST_RECIP) |=> (pc_r == ST_EMIT), "emit step skipped")
  `TPTZ_ASSERT(a_emit_hold, (pc_r == ST_EMIT && stat.out_stall) |=> (pc_r == ST_EMIT), "emit step left while stalled")

endmodule
`default_nettype wire

// ===== design/tptz_dp.sv =====
// Datapath: shared multiplier, accumulator, history, divider and output word.
`timescale 1ns / 1ps
`default_nettype none
`include "two_pole_two_zero_voltage_compensator_macros.svh"
module tptz_dp #(
  parameter int ADC_BITS    = tptz_pkg::ADC_BITS_DEF,
  parameter int PERIOD_BITS = tptz_pkg::PERIOD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tptz_pkg::ctrl_t                     ctrl,
  input  tptz_pkg::cfg_t                      cfg,
  input  logic [PERIOD_BITS-1:0]              period,
  input  logic                                in_accept,
  input  logic [ADC_BITS-1:0]                 adc_code,
  input  logic                                seed_we,
  input  logic [tptz_pkg::SEED_W-1:0]         seed_duty,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [PERIOD_BITS-1:0]              out_cmp,
  output logic [tptz_pkg::DUTY_W-1:0]         out_duty,
  output logic [tptz_pkg::ERR_W-1:0]          out_err,
  output tptz_pkg::stat_t                     stat
);
  import tptz_pkg::*;

  localparam int MA_W  = (PERIOD_BITS + 1 > 17) ? PERIOD_BITS + 1 : 17;
  localparam int MB_W  = (ADC_BITS + 1 > DUTY_W) ? ADC_BITS + 1 : DUTY_W;
  localparam int P_W   = MA_W + MB_W;
  localparam int N_W   = PERIOD_BITS + DC_W;
  localparam int SH_W  = ACC_W - ROUND_SHIFT;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (ROUND_SHIFT - 1);
  // Full duty is an odd factor times a power of two: shift out the power,
  // then divide by the odd factor with a rounded-up reciprocal.
  localparam int DIV_SH  = 10;
  localparam int DIV_ODD = FULL_DUTY >> DIV_SH;
  localparam int Y_W     = N_W - DIV_SH;
  localparam int RK      = Y_W + $clog2(DIV_ODD);
  localparam int R_W     = Y_W + 1;
  localparam longint unsigned RECIP = ((64'd1 << RK) + DIV_ODD - 1) / DIV_ODD;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   sh;
  logic [ADC_BITS-1:0]      code_r;
  logic signed [ERR_W-1:0]  e0_r, e0_nxt, e1_r, e1_nxt, e2_r, e2_nxt;
  logic signed [DUTY_W-1:0] duty_r, duty_nxt, d1_r, d1_nxt, d2_r, d2_nxt;
  logic [DC_W-1:0]          dc;
  logic [Y_W+R_W-1:0]       recip_prod;
  logic [PERIOD_BITS-1:0]   q_r, q_nxt;
  logic                     emit;
  logic                     out_valid_r, out_valid_nxt;
  logic [PERIOD_BITS-1:0]   out_cmp_r, out_cmp_nxt;
  logic [DUTY_W-1:0]        out_duty_r, out_duty_nxt;
  logic [ERR_W-1:0]         out_err_r, out_err_nxt;

  assign stat.out_stall = out_valid_r & ~out_ready;
  assign emit           = (ctrl.op == OP_EMIT) && !stat.out_stall;

  assign out_valid = out_valid_r;
  assign out_cmp   = out_cmp_r;
  assign out_duty  = out_duty_r;
  assign out_err   = out_err_r;

  // Duty clamped to 0..100 percent for the compare value.
  always_comb begin
    if (duty_r[DUTY_W-1]) begin
      dc = '0;
    end else if (duty_r[DUTY_W-2:0] > (DUTY_W-1)'(FULL_DUTY)) begin
      dc = DC_W'(FULL_DUTY);
    end else begin
      dc = duty_r[DC_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_SCALE: begin
        mul_a = MA_W'(VSCALE);
        mul_b = MB_W'(code_r);
      end
      MUL_A1D1: begin
        mul_a = MA_W'($signed(cfg.a1));
        mul_b = MB_W'(d1_r);
      end
      MUL_A2D2: begin
        mul_a = MA_W'($signed(cfg.a2));
        mul_b = MB_W'(d2_r);
      end
      MUL_B0E0: begin
        mul_a = MA_W'($signed(cfg.b0));
        mul_b = MB_W'(e0_r);
      end
      MUL_B1E1: begin
        mul_a = MA_W'($signed(cfg.b1));
        mul_b = MB_W'(e1_r);
      end
      MUL_B2E2: begin
        mul_a = MA_W'($signed(cfg.b2));
        mul_b = MB_W'(e2_r);
      end
      MUL_PDC: begin
        mul_a = MA_W'(period);
        mul_b = MB_W'(dc);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  assign prod_ext   = ACC_W'(prod_r);
  assign rnd        = acc_r + RND_BIAS;
  assign sh         = $signed(rnd[ACC_W-1:ROUND_SHIFT]);
  assign recip_prod = prod_r[N_W-1:DIV_SH] * R_W'(RECIP);

  always_comb begin
    case (ctrl.acc)
      ACC_LOAD16: acc_nxt = prod_ext <<< 4;
      ACC_ADD16:  acc_nxt = acc_r + (prod_ext <<< 4);
      ACC_ADD:    acc_nxt = acc_r + prod_ext;
      default:    acc_nxt = acc_r;
    endcase

    e0_nxt       = e0_r;
    duty_nxt     = duty_r;
    q_nxt        = q_r;
    d1_nxt       = d1_r;
    d2_nxt       = d2_r;
    e1_nxt       = e1_r;
    e2_nxt       = e2_r;
    out_cmp_nxt  = out_cmp_r;
    out_duty_nxt = out_duty_r;
    out_err_nxt  = out_err_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    case (ctrl.op)
      OP_ERR: begin
        e0_nxt = $signed({1'b0, cfg.vref}) - $signed({1'b0, prod_r[ADC_BITS +: REF_W]});
      end
      OP_DUTY: begin
        // Saturate when the upper bits are not a sign extension.
        if (sh[SH_W-1] && !(&sh[SH_W-1:DUTY_W-1])) begin
          duty_nxt = {1'b1, {(DUTY_W-1){1'b0}}};
        end else if (!sh[SH_W-1] && (|sh[SH_W-1:DUTY_W-1])) begin
          duty_nxt = {1'b0, {(DUTY_W-1){1'b1}}};
        end else begin
          duty_nxt = sh[DUTY_W-1:0];
        end
      end
      OP_RECIP: begin
        q_nxt = recip_prod[RK +: PERIOD_BITS];
      end
      OP_EMIT: begin
        if (emit) begin
          out_cmp_nxt   = q_r;
          out_duty_nxt  = duty_r;
          out_err_nxt   = e0_r;
          out_valid_nxt = 1'b1;
          d2_nxt        = d1_r;
          d1_nxt        = duty_r;
          e2_nxt        = e1_r;
          e1_nxt        = e0_r;
        end
      end
      default: begin
        e0_nxt = e0_r;
      end
    endcase

    // Seed the newest duty history entry.
    if (seed_we) begin
      d1_nxt = DUTY_W'(seed_duty);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      d1_r        <= '0;
      d2_r        <= '0;
      e1_r        <= '0;
      e2_r        <= '0;
      duty_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      e1_r        <= e1_nxt;
      e2_r        <= e2_nxt;
      duty_r      <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      code_r <= adc_code;
    end
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    e0_r       <= e0_nxt;
    q_r        <= q_nxt;
    out_cmp_r  <= out_cmp_nxt;
    out_duty_r <= out_duty_nxt;
    out_err_r  <= out_err_nxt;
  end

  `TPTZ_NEVER(a_dc_range, dc > DC_W'(FULL_DUTY), "clamped duty above full scale")
  `TPTZ_ASSERT(a_quot_bound, (ctrl.op == OP_EMIT) |-> (q_r <= period), "compare above period")
  `TPTZ_ASSERT(a_emit_load, emit |=> out_valid_r, "result word not loaded")

endmodule
`default_nettype wire

// ===== design/two_pole_two_zero_voltage_compensator.sv =====
// Two-pole two-zero output voltage compensator, top level.
//
// Input stream: one ADC code of the divided output voltage per word on
// in_tdata. Output stream: one word per input word holding the PWM compare
// value, the new unclamped duty (1/256 percent) and the voltage error.
// Configuration: cfg_index selects a register (reference, five Q2.14
// coefficients, PWM period, initial duty), cfg_data carries the value; a
// write to the initial duty also loads the newest duty history entry.
// Write configuration only while the block is idle.
// A word runs through a 12-step microprogram on one shared multiplier; the
// compare value comes from a reciprocal multiply by the constant full-scale
// duty. out_tvalid is set by the emit step, and a new word is taken only
// after the previous word has passed the emit step.
// in_tready is high while the sequencer waits at its first step; the next
// word can be taken while the previous result still sits in the output
// register. If the receiver stalls, the sequencer holds at its last step
// until the output register frees up.
// Reset loads the default registers, clears the duty and error history and
// drops out_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module two_pole_two_zero_voltage_compensator #(
  parameter int ADC_BITS    = tptz_pkg::ADC_BITS_DEF,
  parameter int PERIOD_BITS = tptz_pkg::PERIOD_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // adc_code
  input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0]             in_tdata,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // compare_value, duty_level, voltage_error
  output logic [((PERIOD_BITS + 41 + 7) / 8) * 8 - 1:0]     out_tdata,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [tptz_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [((PERIOD_BITS > 16) ? PERIOD_BITS : 16) - 1:0] cfg_data
);
  import tptz_pkg::*;

  localparam int OUT_W = ((PERIOD_BITS + DUTY_W + ERR_W + 7) / 8) * 8;

  cfg_t                   cfg_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic                   cfg_we;
  logic                   seed_we;
  ctrl_t                  ctrl;
  stat_t                  stat;
  logic                   in_accept;
  logic [PERIOD_BITS-1:0] out_cmp;
  logic [DUTY_W-1:0]      out_duty;
  logic [ERR_W-1:0]       out_err;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign seed_we   = cfg_we && (cfg_index == REG_SEED);
  assign in_accept = in_tvalid & in_tready;
  assign out_tdata = OUT_W'({out_err, out_duty, out_cmp});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vref <= VREF_RST;
      cfg_r.a1   <= A1_RST;
      cfg_r.a2   <= A2_RST;
      cfg_r.b0   <= B0_RST;
      cfg_r.b1   <= B1_RST;
      cfg_r.b2   <= B2_RST;
      period_r   <= PERIOD_BITS'(PERIOD_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VREF:   cfg_r.vref <= cfg_data[REF_W-1:0];
        REG_A1:     cfg_r.a1   <= cfg_data[COEF_W-1:0];
        REG_A2:     cfg_r.a2   <= cfg_data[COEF_W-1:0];
        REG_B0:     cfg_r.b0   <= cfg_data[COEF_W-1:0];
        REG_B1:     cfg_r.b1   <= cfg_data[COEF_W-1:0];
        REG_B2:     cfg_r.b2   <= cfg_data[COEF_W-1:0];
        REG_PERIOD: period_r   <= cfg_data[PERIOD_BITS-1:0];
        default:    period_r   <= period_r;
      endcase
    end
  end

  tptz_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_tready)
  );

  tptz_dp #(
    .ADC_BITS    (ADC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg_r),
    .period    (period_r),
    .in_accept (in_accept),
    .adc_code  (in_tdata[ADC_BITS-1:0]),
    .seed_we   (seed_we),
    .seed_duty (cfg_data[SEED_W-1:0]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_cmp   (out_cmp),
    .out_duty  (out_duty),
    .out_err   (out_err),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 2P2Z voltage compensator: directed table, then random phases.
module tb;
  import tptz_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int MAX_PRINTS    = 100;

  // Field order matches out_tdata from the top bit down.
  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [DUTY_W-1:0] duty;
    logic [15:0]       compare;
  } comp_word_t;

  typedef struct {
    bit         is_cfg;
    cfg_reg_t   idx;
    logic [15:0] value;
    bit         known;
    comp_word_t want;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // adc_code
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // compare_value, duty_level, voltage_error
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [15:0] cfg_data;

  // Mirror of the block's registers and history.
  logic [15:0]        vref_q;
  logic [15:0]        period_q;
  logic signed [15:0] a1_q, a2_q, b0_q, b1_q, b2_q;
  int                 duty_h1, duty_h2, err_h1, err_h2;

  comp_word_t pending_results[$];
  int         errors;
  int         in_idle_pct;
  int         out_idle_pct;
  bit         hold_req;
  int         cycle_count;

  two_pole_two_zero_voltage_compensator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run one ADC sample through the control law and advance the history.
  function automatic comp_word_t compensate_sample(logic [15:0] word);
    longint     code, measured, e0, acc, duty, dc, cmp;
    comp_word_t r;
    code     = longint'(word[ADC_BITS_DEF-1:0]);
    measured = (code * 40560) >>> ADC_BITS_DEF;
    e0       = longint'(vref_q) - measured;
    acc = 16 * (longint'(a1_q) * duty_h1 + longint'(a2_q) * duty_h2)
        + longint'(b0_q) * e0 + longint'(b1_q) * err_h1 + longint'(b2_q) * err_h2;
    // floor of (acc + half) / 2^18 rounds to nearest, ties up
    duty = (acc + 131072) >>> 18;
    if (duty > 8388607) duty = 8388607;
    if (duty < -8388608) duty = -8388608;
    dc = duty;
    if (dc < 0) dc = 0;
    if (dc > 25600) dc = 25600;
    cmp = (longint'(period_q) * dc) / 25600;
    err_h2  = err_h1;
    err_h1  = int'(e0);
    duty_h2 = duty_h1;
    duty_h1 = int'(duty);
    r.compare = cmp[15:0];
    r.duty    = duty[DUTY_W-1:0];
    r.err     = e0[ERR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_result(logic [63:0] word);
    comp_word_t got, want;
    got = word[$bits(comp_word_t)-1:0];
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %h", got));
    end else begin
      want = pending_results.pop_front();
      if (got.compare !== want.compare)
        report_mismatch($sformatf("compare got %0d want %0d", got.compare, want.compare));
      if (got.duty !== want.duty)
        report_mismatch($sformatf("duty got %0d want %0d",
                                  $signed(got.duty), $signed(want.duty)));
      if (got.err !== want.err)
        report_mismatch($sformatf("error got %0d want %0d",
                                  $signed(got.err), $signed(want.err)));
    end
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VREF:   vref_q = value;
      REG_A1:     a1_q = value;
      REG_A2:     a2_q = value;
      REG_B0:     b0_q = value;
      REG_B1:     b1_q = value;
      REG_B2:     b2_q = value;
      REG_PERIOD: period_q = value;
      REG_SEED:   duty_h1 = int'(value[SEED_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one sample word; expect the typed result when known, else the predicted one.
  task automatic send_word(logic [15:0] word, bit known, comp_word_t typed);
    comp_word_t predicted;
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    predicted = compensate_sample(word);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // Drop valid and wait for every pending result, plus a short margin.
  task automatic wait_until_settled();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic step_t cfg_row(cfg_reg_t idx, logic [15:0] value);
    step_t r;
    r = '{is_cfg: 1'b1, idx: idx, value: value, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic step_t item_row(logic [15:0] code);
    step_t r;
    r = '{is_cfg: 1'b0, idx: REG_VREF, value: code, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic step_t known_row(logic [15:0] code, int cmp, int duty, int err);
    step_t r;
    r = item_row(code);
    r.known        = 1'b1;
    r.want.compare = cmp[15:0];
    r.want.duty    = duty[DUTY_W-1:0];
    r.want.err     = err[ERR_W-1:0];
    return r;
  endfunction

  // Receiver: check accepted words, then pick the next ready level.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    step_t       plan[$];
    step_t       row;
    bit          last_was_item;
    int          idle_plan[3][2];
    int          done, len, kind;
    logic [15:0] coefs[5];
    logic [15:0] word, vref_v, period_v, seed_v;
    logic [15:0] rst_coefs[5];
    logic [15:0] edge_coefs[3];
    int          center;

    rst_coefs  = '{A1_RST, A2_RST, B0_RST, B1_RST, B2_RST};
    edge_coefs = '{16'h8000, 16'h7FFF, 16'h0000};
    idle_plan  = '{'{22, 86}, '{86, 22}, '{0, 0}};

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_VREF;
    cfg_data  = '0;
    hold_req  = 1'b0;
    errors    = 0;
    in_idle_pct  = 10;
    out_idle_pct = 10;

    vref_q   = VREF_RST;
    a1_q     = A1_RST;
    a2_q     = A2_RST;
    b0_q     = B0_RST;
    b1_q     = B1_RST;
    b2_q     = B2_RST;
    period_q = 16'(PERIOD_RST);
    duty_h1  = 0;
    duty_h2  = 0;
    err_h1   = 0;
    err_h2   = 0;

    // Defaults after reset, then zeroed coefficients so results read off directly.
    plan.push_back(item_row(16'h0000));
    plan.push_back(item_row(16'hFFFF));
    plan.push_back(cfg_row(REG_A1, 16'h0000));
    plan.push_back(cfg_row(REG_A2, 16'h0000));
    plan.push_back(cfg_row(REG_B0, 16'h0000));
    plan.push_back(cfg_row(REG_B1, 16'h0000));
    plan.push_back(cfg_row(REG_B2, 16'h0000));
    plan.push_back(cfg_row(REG_VREF, 16'd0));
    plan.push_back(known_row(16'h0000, 0, 0, 0));
    plan.push_back(known_row(16'h0FFF, 0, 0, -40550));
    plan.push_back(cfg_row(REG_VREF, 16'd40960));
    // upper bits above the ADC width must be ignored
    plan.push_back(known_row(16'hF000, 0, 0, 40960));
    plan.push_back(cfg_row(REG_B0, 16'h4000));
    plan.push_back(cfg_row(REG_PERIOD, 16'd25600));
    plan.push_back(known_row(16'h0000, 2560, 2560, 40960));
    plan.push_back(cfg_row(REG_B0, 16'hC000));
    plan.push_back(known_row(16'h0000, 0, -2560, 40960));
    // unity integrator seeded at full duty
    plan.push_back(cfg_row(REG_B0, 16'h0000));
    plan.push_back(cfg_row(REG_A1, 16'h4000));
    plan.push_back(cfg_row(REG_SEED, 16'd25600));
    plan.push_back(known_row(16'h0000, 25600, 25600, 40960));
    plan.push_back(known_row(16'h0ABC, 25600, 25600, 40960 - ((16'h0ABC * 40560) >> 12)));
    plan.push_back(cfg_row(REG_PERIOD, 16'd65535));
    plan.push_back(known_row(16'h0000, 65535, 25600, 40960));
    plan.push_back(cfg_row(REG_PERIOD, 16'd0));
    plan.push_back(known_row(16'h0000, 0, 25600, 40960));
    // duty above full scale, then drive into positive saturation
    plan.push_back(cfg_row(REG_PERIOD, 16'd6400));
    plan.push_back(cfg_row(REG_A1, 16'h7FFF));
    plan.push_back(item_row(16'h0000));
    plan.push_back(cfg_row(REG_A2, 16'h7FFF));
    plan.push_back(cfg_row(REG_B0, 16'h7FFF));
    plan.push_back(cfg_row(REG_B1, 16'h7FFF));
    plan.push_back(cfg_row(REG_B2, 16'h7FFF));
    repeat (6) plan.push_back(item_row(16'h0000));
    // swing to negative saturation
    plan.push_back(cfg_row(REG_A1, 16'h8000));
    plan.push_back(cfg_row(REG_A2, 16'h8000));
    plan.push_back(cfg_row(REG_B0, 16'h8000));
    plan.push_back(cfg_row(REG_B1, 16'h8000));
    plan.push_back(cfg_row(REG_B2, 16'h8000));
    plan.push_back(item_row(16'h0FFF));
    plan.push_back(item_row(16'h0000));
    // stored errors keep the old reference
    plan.push_back(cfg_row(REG_A1, A1_RST));
    plan.push_back(cfg_row(REG_A2, A2_RST));
    plan.push_back(cfg_row(REG_B0, B0_RST));
    plan.push_back(cfg_row(REG_B1, B1_RST));
    plan.push_back(cfg_row(REG_B2, B2_RST));
    plan.push_back(cfg_row(REG_VREF, 16'd0));
    plan.push_back(item_row(16'h0800));
    plan.push_back(cfg_row(REG_SEED, 16'd0));
    plan.push_back(item_row(16'h0400));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    last_was_item = 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (last_was_item) wait_until_settled();
        cfg_write(row.idx, row.value);
        last_was_item = 1'b0;
      end else begin
        send_word(row.value, row.known, row.want);
        last_was_item = 1'b1;
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = idle_plan[ph][0];
      out_idle_pct = idle_plan[ph][1];
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        wait_until_settled();
        kind = $urandom_range(3);
        for (int c = 0; c < 5; c++) begin
          case (kind)
            0:       coefs[c] = rst_coefs[c];
            1:       coefs[c] = 16'($urandom_range(0, 65535));
            2:       coefs[c] = edge_coefs[$urandom_range(2)];
            default: coefs[c] = 16'($urandom_range(0, 8191) - 4096);
          endcase
        end
        if (kind == 2) begin
          vref_v   = $urandom_range(1) ? 16'd40960 : 16'd0;
          period_v = $urandom_range(1) ? 16'd65535 : 16'd1;
          seed_v   = $urandom_range(1) ? 16'd25600 : 16'd0;
        end else begin
          vref_v   = 16'($urandom_range(0, 40960));
          period_v = 16'($urandom_range(1, 65535));
          seed_v   = 16'($urandom_range(0, 25600));
        end
        cfg_write(REG_VREF, vref_v);
        cfg_write(REG_A1, coefs[0]);
        cfg_write(REG_A2, coefs[1]);
        cfg_write(REG_B0, coefs[2]);
        cfg_write(REG_B1, coefs[3]);
        cfg_write(REG_B2, coefs[4]);
        cfg_write(REG_PERIOD, period_v);
        if (kind == 2 || $urandom_range(1)) cfg_write(REG_SEED, seed_v);

        // stall the receiver at the start of each phase so the input backs up
        if (done == 0) hold_req = 1'b1;
        center = (int'(vref_q) * 4096) / 40560;
        len = $urandom_range(40, 120);
        for (int k = 0; k < len; k++) begin
          if (k == len / 2 && $urandom_range(2) == 0) wait_until_settled();
          case ($urandom_range(9))
            0: word = {4'($urandom_range(15)), 12'h000};
            1: word = {4'($urandom_range(15)), 12'hFFF};
            2, 3: word = {4'($urandom_range(15)),
                          12'(center + $urandom_range(0, 64) - 32)};
            default: word = 16'($urandom_range(0, 65535));
          endcase
          send_word(word, 1'b0, '0);
        end
        done += len;
      end
    end

    wait_until_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
